/* rtl/eks_pkg.sv */
// Shared types and constants of the expiry key slab table.
`timescale 1ns / 1ps

package eks_pkg;

  localparam int KEY_W       = 64;
  localparam int EXP_W       = 64;
  localparam int OPC_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int IN_INDEX_W  = 4;
  localparam int MAX_RESULTS = 16;
  localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_LOOKUP  = 3'd1,
    OP_DEL_KEY = 3'd2,
    OP_DEL_IDX = 3'd3,
    OP_UPDATE  = 3'd4,
    OP_MIN     = 3'd5,
    OP_LIST    = 3'd6
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_UPD,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [KEY_W-1:0]        key;
    logic signed [EXP_W-1:0] expire;
    logic [KEY_W-1:0]        new_key;
    logic signed [EXP_W-1:0] repl_expire;
    logic [IN_INDEX_W-1:0]   index;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [EXP_W-1:0] expire;
  } entry_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } emit_t;

endpackage

/* rtl/expiry_key_slab_table.sv */
// Expiry key slab table: one item at a time, (key, expiry) pairs in one synchronous RAM.
// Insert appends behind the last entry; delete by index moves the last entry into the
//   freed slot (a bad index skips the move); the other items scan the packed entries.
// Throughput: one item at a time; scans read one entry per cycle through the single
//   RAM read port, except while a list result is held back by the output stall.
// Reset: clears the entry count and control state; RAM contents are not cleared.
`timescale 1ns / 1ps

module expiry_key_slab_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  eks_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output eks_pkg::res_t out_o
);

  localparam int IdxW   = $clog2(TABLE_DEPTH);
  localparam int CntW   = $clog2(TABLE_DEPTH + 1);
  localparam int CmpW   = (CntW > eks_pkg::IN_INDEX_W) ? CntW : eks_pkg::IN_INDEX_W;
  localparam int PosW   = eks_pkg::POS_W;
  localparam int CountW = eks_pkg::COUNT_W;
  localparam int HitW   = eks_pkg::HIT_W;

  eks_pkg::state_e state_q, state_d;
  eks_pkg::in_t    req_q, req_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_idx_q, scan_idx_d;
  logic            cmp_v_q, cmp_v_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [eks_pkg::STATUS_W-1:0] status_q, status_d;
  logic            best_v_q, best_v_d;
  logic [eks_pkg::KEY_W-1:0]        best_key_q, best_key_d;
  logic signed [eks_pkg::EXP_W-1:0] best_exp_q, best_exp_d;
  logic            pend_v_q, pend_v_d;
  logic [HitW-1:0] hits_q, hits_d;

  eks_pkg::entry_t mem [TABLE_DEPTH];
  eks_pkg::entry_t rd_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  eks_pkg::entry_t mem_wdata;

  eks_pkg::emit_t  emit;
  logic            emit_ready;

  logic            find_op, is_list, is_min;
  logic            match, hit, better, emit_need, adv;
  logic            issue_more, scan_end, idx_bad, table_full;
  logic [CntW-1:0] last_idx;

  assign find_op = (req_q.opcode == eks_pkg::OP_LOOKUP) ||
                   (req_q.opcode == eks_pkg::OP_DEL_KEY) ||
                   (req_q.opcode == eks_pkg::OP_UPDATE);
  assign is_list = (req_q.opcode == eks_pkg::OP_LIST);
  assign is_min  = (req_q.opcode == eks_pkg::OP_MIN);

  assign match  = cmp_v_q && (rd_q.key == req_q.key) && (rd_q.expire == req_q.expire);
  assign hit    = is_list && cmp_v_q && (rd_q.expire <= req_q.expire) &&
                  (hits_q < HitW'(eks_pkg::MAX_RESULTS));
  assign better = !best_v_q || (rd_q.expire < best_exp_q) ||
                  ((rd_q.expire == best_exp_q) && (rd_q.key < best_key_q));

  assign emit_need  = (state_q == eks_pkg::S_SCAN) && hit && pend_v_q;
  assign adv        = !emit_need || emit_ready;
  assign issue_more = (scan_idx_q < count_q) &&
                      (!is_list || (hits_q < HitW'(eks_pkg::MAX_RESULTS)));
  assign scan_end   = !issue_more && !cmp_v_q;
  assign idx_bad    = CmpW'(in_i.index) >= CmpW'(count_q);
  assign table_full = count_q >= CntW'(TABLE_DEPTH);
  assign last_idx   = count_q - 1'b1;

  assign in_stall_o = (state_q != eks_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      eks_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_i.opcode)
            eks_pkg::OP_INSERT:  state_d = eks_pkg::S_INS;
            eks_pkg::OP_LOOKUP,
            eks_pkg::OP_DEL_KEY,
            eks_pkg::OP_UPDATE,
            eks_pkg::OP_MIN,
            eks_pkg::OP_LIST:    state_d = eks_pkg::S_SCAN;
            eks_pkg::OP_DEL_IDX: state_d = idx_bad ? eks_pkg::S_EMIT : eks_pkg::S_MOVE_RD;
            default:             state_d = eks_pkg::S_IDLE;
          endcase
        end
      end
      eks_pkg::S_INS: state_d = eks_pkg::S_EMIT;
      eks_pkg::S_SCAN: begin
        if (find_op && match) begin
          priority if (req_q.opcode == eks_pkg::OP_DEL_KEY) begin
            state_d = eks_pkg::S_MOVE_RD;
          end else if (req_q.opcode == eks_pkg::OP_UPDATE) begin
            state_d = eks_pkg::S_UPD;
          end else begin
            state_d = eks_pkg::S_EMIT;
          end
        end else if (scan_end) begin
          state_d = eks_pkg::S_EMIT;
        end
      end
      eks_pkg::S_MOVE_RD: state_d = eks_pkg::S_MOVE_WR;
      eks_pkg::S_MOVE_WR: state_d = eks_pkg::S_EMIT;
      eks_pkg::S_UPD:     state_d = eks_pkg::S_EMIT;
      eks_pkg::S_EMIT: begin
        if (emit_ready) begin
          state_d = eks_pkg::S_IDLE;
        end
      end
      default: state_d = eks_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_d      = req_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    cmp_v_d    = cmp_v_q;
    cmp_idx_d  = cmp_idx_q;
    pos_d      = pos_q;
    status_d   = status_q;
    best_v_d   = best_v_q;
    best_key_d = best_key_q;
    best_exp_d = best_exp_q;
    pend_v_d   = pend_v_q;
    hits_d     = hits_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = pos_q;
    mem_raddr  = scan_idx_q[IdxW-1:0];
    mem_wdata  = rd_q;
    emit.valid         = 1'b0;
    emit.data.status   = eks_pkg::ST_OK;
    emit.data.position = PosW'(pos_q);
    emit.data.count    = CountW'(count_q);
    emit.data.last     = 1'b0;

    unique case (state_q)
      eks_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_i;
          scan_idx_d = '0;
          cmp_v_d    = 1'b0;
          hits_d     = '0;
          pend_v_d   = 1'b0;
          best_v_d   = 1'b0;
          pos_d      = '0;
          status_d   = eks_pkg::ST_OK;
          if (in_i.opcode == eks_pkg::OP_DEL_IDX) begin
            if (idx_bad) begin
              status_d = eks_pkg::ST_BAD_INDEX;
            end else begin
              pos_d = IdxW'(in_i.index);
            end
          end
        end
      end
      eks_pkg::S_INS: begin
        if (table_full) begin
          status_d = eks_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = count_q[IdxW-1:0];
          mem_wdata = '{key: req_q.key, expire: req_q.expire};
          pos_d     = count_q[IdxW-1:0];
          count_d   = count_q + 1'b1;
        end
      end
      eks_pkg::S_SCAN: begin
        if (adv) begin
          if (issue_more) begin
            mem_re     = 1'b1;
            scan_idx_d = scan_idx_q + 1'b1;
            cmp_v_d    = 1'b1;
            cmp_idx_d  = scan_idx_q[IdxW-1:0];
          end else begin
            cmp_v_d = 1'b0;
          end
        end
        if (find_op && match) begin
          pos_d = cmp_idx_q;
        end
        if (is_min && cmp_v_q && better) begin
          best_v_d   = 1'b1;
          best_key_d = rd_q.key;
          best_exp_d = rd_q.expire;
          pos_d      = cmp_idx_q;
        end
        if (hit && adv) begin
          pend_v_d = 1'b1;
          hits_d   = hits_q + 1'b1;
          pos_d    = cmp_idx_q;
        end
        emit.valid = emit_need;
        if (scan_end) begin
          priority if (find_op) begin
            status_d = eks_pkg::ST_NOT_FOUND;
          end else if (is_min) begin
            status_d = best_v_q ? eks_pkg::ST_OK : eks_pkg::ST_EMPTY;
          end else begin
            status_d = pend_v_q ? eks_pkg::ST_OK : eks_pkg::ST_EMPTY;
          end
        end
      end
      eks_pkg::S_MOVE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = last_idx[IdxW-1:0];
      end
      eks_pkg::S_MOVE_WR: begin
        mem_we  = 1'b1;
        count_d = count_q - 1'b1;
      end
      eks_pkg::S_UPD: begin
        mem_we    = 1'b1;
        mem_wdata = '{key: req_q.new_key, expire: req_q.repl_expire};
      end
      eks_pkg::S_EMIT: begin
        emit.valid       = 1'b1;
        emit.data.status = status_q;
        emit.data.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= eks_pkg::S_IDLE;
      count_q    <= '0;
      scan_idx_q <= '0;
      cmp_v_q    <= 1'b0;
      best_v_q   <= 1'b0;
      pend_v_q   <= 1'b0;
      hits_q     <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      cmp_v_q    <= cmp_v_d;
      best_v_q   <= best_v_d;
      pend_v_q   <= pend_v_d;
      hits_q     <= hits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    cmp_idx_q  <= cmp_idx_d;
    pos_q      <= pos_d;
    status_q   <= status_d;
    best_key_q <= best_key_d;
    best_exp_q <= best_exp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  eks_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) ||
             (count_q == CntW'($past(count_q) + 1'b1)) ||
             (count_q == CntW'($past(count_q) - 1'b1)))
    else $error("entry count moved by more than one");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CntW'(mem_waddr) < count_q) || (state_q == eks_pkg::S_INS))
    else $error("write outside the packed entries");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid && emit_ready && emit.data.last |=> state_q == eks_pkg::S_IDLE)
    else $error("final result did not end the transaction");

  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eks_pkg::S_SCAN) && emit.valid && !emit_ready |=> $stable(scan_idx_q))
    else $error("scan advanced while a result was blocked");
`endif

endmodule

/* rtl/eks_out_reg.sv */
// Output register between the table engine and the result channel.
`timescale 1ns / 1ps

module eks_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  eks_pkg::emit_t emit_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output eks_pkg::res_t out_o
);

  logic          valid_q, valid_d;
  eks_pkg::res_t data_q;
  logic          load;

  assign ready_o = !valid_q || !out_stall_i;
  assign load    = emit_i.valid && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= emit_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
